/* hdl/slbs_pkg.sv */
// Shared types, codes and the blink pattern table for the status LED sequencer.
// No dependencies; every other file imports this package.
package slbs_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int MS_W     = 11;
  localparam int PAT_W    = 3;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
  localparam logic [OP_W-1:0] OP_PULSE  = 2'd2;

  // Status codes (anything above error is treated as error)
  localparam logic [STATUS_W-1:0] ST_BOOTING  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CRITICAL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;

  // Pattern indexes
  localparam logic [PAT_W-1:0] PAT_BOOTING = 3'd0;
  localparam logic [PAT_W-1:0] PAT_READY   = 3'd1;
  localparam logic [PAT_W-1:0] PAT_WARNING = 3'd2;
  localparam logic [PAT_W-1:0] PAT_CRIT    = 3'd3;
  localparam logic [PAT_W-1:0] PAT_ERROR   = 3'd4;
  localparam logic [PAT_W-1:0] PAT_PULSE   = 3'd5;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [MS_W-1:0]     on_ms;
    logic [MS_W-1:0]     off_ms;
  } pat_row_t;

  // Sequencer state, all but the pulse counter (its width follows a top parameter)
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    phase_t              phase;
    logic [MS_W-1:0]     remaining;
    logic [PAT_W-1:0]    pattern;
    logic [COLOUR_W-1:0] colour;
  } slbs_state_t;

  // colour R:G:B / on ms / off ms
  function automatic pat_row_t pattern_row(input logic [PAT_W-1:0] p);
    pat_row_t row;
    case (p)
      PAT_BOOTING: row = '{colour: 24'h000008, on_ms: 11'd120, off_ms: 11'd380};
      PAT_READY:   row = '{colour: 24'h000600, on_ms: 11'd40,  off_ms: 11'd1960};
      PAT_WARNING: row = '{colour: 24'h0A0600, on_ms: 11'd100, off_ms: 11'd400};
      PAT_CRIT:    row = '{colour: 24'h0C0000, on_ms: 11'd80,  off_ms: 11'd80};
      PAT_PULSE:   row = '{colour: 24'h000808, on_ms: 11'd60,  off_ms: 11'd60};
      default:     row = '{colour: 24'h0A0000, on_ms: 11'd180, off_ms: 11'd180};
    endcase
    return row;
  endfunction

endpackage

/* hdl/slbs_in_if.sv */
// Input channel of the status LED sequencer: valid/ready plus one item word.
// Depends on slbs_pkg.
interface slbs_in_if
  import slbs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [STATUS_W-1:0] status_value;

  modport source (output valid, operation, status_value, input ready);
  modport sink   (input valid, operation, status_value, output ready);
endinterface

/* hdl/slbs_out_if.sv */
// Result channel of the status LED sequencer: valid/ready plus LED colour word.
// Depends on slbs_pkg.
interface slbs_out_if
  import slbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] led_red;
  logic [CHAN_W-1:0] led_green;
  logic [CHAN_W-1:0] led_blue;
  logic              frame_write;

  modport source (output valid, led_red, led_green, led_blue, frame_write, input ready);
  modport sink   (input valid, led_red, led_green, led_blue, frame_write, output ready);
endinterface

/* hdl/slbs_step.sv */
// Next-state logic of the sequencer for one word: tick timing, status, pulse count.
// Depends on slbs_pkg.
module slbs_step
  import slbs_pkg::*;
#(
  parameter int MAX_PENDING_PULSES = 3,
  parameter int PW                 = $clog2(MAX_PENDING_PULSES + 1)
) (
  input  logic [OP_W-1:0]     operation,
  input  logic [STATUS_W-1:0] status_value,
  input  slbs_state_t         st,
  input  logic [PW-1:0]       pulses,
  output slbs_state_t         st_nxt,
  output logic [PW-1:0]       pulses_nxt,
  output logic                frame_write
);

  slbs_state_t      t;
  logic [MS_W-1:0]  rem_dec;
  logic [PAT_W-1:0] pat;
  pat_row_t         row_off;
  pat_row_t         row_on;
  logic             take_pulse;
  logic [PAT_W-1:0] status_pat;

  always_comb begin
    status_pat = (st.status > ST_ERROR) ? PAT_ERROR : PAT_W'(st.status);
    take_pulse = (pulses != '0) && (st.status < ST_CRITICAL);
    pat        = take_pulse ? PAT_PULSE : status_pat;
    row_on     = pattern_row(pat);
    row_off    = pattern_row(st.pattern);
    rem_dec    = (st.remaining != '0) ? st.remaining - 1'b1 : st.remaining;
  end

  always_comb begin
    t           = st;
    pulses_nxt  = pulses;
    frame_write = 1'b0;
    case (operation)
      OP_TICK: begin
        if (st.phase == PH_ON || st.phase == PH_OFF) begin
          t.remaining = rem_dec;
          if (rem_dec == '0) begin
            if (st.phase == PH_ON) begin
              t.colour    = '0;
              t.remaining = row_off.off_ms;
              t.phase     = PH_OFF;
              frame_write = 1'b1;
            end else begin
              t.phase = PH_START;
            end
          end
        end
        // cycle start, possibly in the same tick that ended the off time
        if (t.phase != PH_ON && t.phase != PH_OFF) begin
          if (take_pulse) begin
            pulses_nxt = pulses - 1'b1;
          end
          t.pattern   = pat;
          t.colour    = row_on.colour;
          t.remaining = row_on.on_ms;
          t.phase     = PH_ON;
          frame_write = 1'b1;
        end
      end
      OP_STATUS: begin
        t.status = status_value;
      end
      OP_PULSE: begin
        if (pulses < PW'(MAX_PENDING_PULSES)) begin
          pulses_nxt = pulses + 1'b1;
        end
      end
      default: begin
      end
    endcase
    st_nxt = t;
  end

endmodule

/* hdl/status_led_blink_sequencer.sv */
// Status LED blink sequencer: turns millisecond ticks, status updates and
// receive-pulse words into RGB colour words for a status LED, one result word
// per input word. Pulses are counted up to MAX_PENDING_PULSES; at each blink
// cycle start one pending pulse is shown as cyan 60 ms on / 60 ms off unless
// the status is critical or error, otherwise the status pattern plays. A cycle
// is never cut short by a status change. frame_write marks words on which the
// colour was rewritten. Throughput is one word per clock while out_ch.ready
// stays high. A word taken into the input register is processed by the
// combinational next-state logic, and its result is registered in the result
// register that drives out_ch, where it waits to be taken. While a finished
// result waits on out_ch.ready, both stages hold. One more word can still
// enter the input register if it is empty, and in_ch.ready then stays low
// until the result is taken.
// Depends on slbs_pkg, slbs_in_if, slbs_out_if and slbs_step.
module status_led_blink_sequencer
  import slbs_pkg::*;
#(
  parameter int MAX_PENDING_PULSES = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  slbs_in_if.sink           in_ch,
  slbs_out_if.source        out_ch
);

  localparam int PW = $clog2(MAX_PENDING_PULSES + 1);

  // Input register
  logic                in_valid_r;
  logic [OP_W-1:0]     in_op_r;
  logic [STATUS_W-1:0] in_sv_r;

  // Sequencer state
  slbs_state_t         st_r;
  slbs_state_t         st_nxt;
  logic [PW-1:0]       pulses_r;
  logic [PW-1:0]       pulses_nxt;
  logic                frame_nxt;

  // Result register
  logic                out_valid_r;
  logic [COLOUR_W-1:0] out_colour_r;
  logic                out_frame_r;

  logic                adv;      // result register can take a word
  logic                commit;   // word in the input register is processed

  assign adv         = !out_valid_r || out_ch.ready;
  assign commit      = in_valid_r && adv;
  assign in_ch.ready = !in_valid_r || adv;

  slbs_step #(
    .MAX_PENDING_PULSES (MAX_PENDING_PULSES),
    .PW                 (PW)
  ) u_step (
    .operation    (in_op_r),
    .status_value (in_sv_r),
    .st           (st_r),
    .pulses       (pulses_r),
    .st_nxt       (st_nxt),
    .pulses_nxt   (pulses_nxt),
    .frame_write  (frame_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pulses_r    <= '0;
      st_r        <= '{status: ST_BOOTING, phase: PH_START, remaining: '0,
                       pattern: PAT_BOOTING, colour: '0};
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      // state moves only when a word leaves the input register
      if (commit) begin
        st_r     <= st_nxt;
        pulses_r <= pulses_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r <= in_ch.operation;
      in_sv_r <= in_ch.status_value;
    end
    if (commit) begin
      out_colour_r <= st_nxt.colour;
      out_frame_r  <= frame_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led_red     = out_colour_r[3*CHAN_W-1:2*CHAN_W];
  assign out_ch.led_green   = out_colour_r[2*CHAN_W-1:CHAN_W];
  assign out_ch.led_blue    = out_colour_r[CHAN_W-1:0];
  assign out_ch.frame_write = out_frame_r;

endmodule
